@@ sv/bic_pkg.sv @@
// ----------------------------------------------------------------------------
// bic_pkg
// shared widths, constants and stage types of the bicubic interpolation kernel
// ----------------------------------------------------------------------------
package bic_pkg;

    localparam int PIX_W        = 8;
    localparam int ROW_BITS     = 4 * PIX_W;
    localparam int FRAC_FIELD_W = 8;
    localparam int WEIGHT_BITS  = 12;
    localparam int WGT_W        = WEIGHT_BITS + 2;
    localparam int PROD_W       = WGT_W + PIX_W + 1;
    localparam int ROW_W        = PROD_W + 2;
    localparam int VPROD_W      = WGT_W + ROW_W;
    localparam int SUM_W        = VPROD_W + 2;

    typedef logic [3:0][ROW_BITS-1:0] rows_t;
    typedef logic [3:0][WGT_W-1:0]    wgt_vec_t;

    // weights ready, neighbourhood delayed alongside
    typedef struct packed {
        logic     valid;
        rows_t    rows;
        wgt_vec_t wx;
        wgt_vec_t wy;
    } wgt_stage_t;

    // exact filtered value in units of 2^-(2*WEIGHT_BITS)
    typedef struct packed {
        logic                    valid;
        logic signed [SUM_W-1:0] sum;
    } sum_stage_t;

endpackage

@@ sv/bic_if.sv @@
// ----------------------------------------------------------------------------
// bic_in_if / bic_out_if
// valid/ready channels for neighbourhood items and interpolated pixels
// ----------------------------------------------------------------------------
interface bic_in_if;
    import bic_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [ROW_BITS-1:0]     row0_pixels;
    logic [ROW_BITS-1:0]     row1_pixels;
    logic [ROW_BITS-1:0]     row2_pixels;
    logic [ROW_BITS-1:0]     row3_pixels;
    logic [FRAC_FIELD_W-1:0] frac_x;
    logic [FRAC_FIELD_W-1:0] frac_y;

    modport source (
        output valid, row0_pixels, row1_pixels, row2_pixels, row3_pixels, frac_x, frac_y,
        input  ready
    );
    modport sink (
        input  valid, row0_pixels, row1_pixels, row2_pixels, row3_pixels, frac_x, frac_y,
        output ready
    );
endinterface

interface bic_out_if;
    import bic_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_out;
    logic             clipped;

    modport source (
        output valid, pixel_out, clipped,
        input  ready
    );
    modport sink (
        input  valid, pixel_out, clipped,
        output ready
    );
endinterface

@@ sv/bic_weight_gen.sv @@
// ----------------------------------------------------------------------------
// bic_weight_gen
// three-stage catmull-rom weight generator for frac_x and frac_y
// ----------------------------------------------------------------------------
module bic_weight_gen #(
    parameter int FRAC_BITS = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  logic                                in_valid,
    input  bic_pkg::rows_t                      in_rows,
    input  logic [bic_pkg::FRAC_FIELD_W-1:0]    frac_x,
    input  logic [bic_pkg::FRAC_FIELD_W-1:0]    frac_y,
    output bic_pkg::wgt_stage_t                 wgt_out
);
    import bic_pkg::*;

    localparam int F      = FRAC_BITS;
    localparam int G_W    = F + 1;
    localparam int F2_W   = 2 * F;
    localparam int G2_W   = 2 * F + 2;
    localparam int K_W    = F + 3;
    localparam int H_W    = 2 * F + 3;
    localparam int CUBE_W = 3 * F + 2;
    localparam int W2_W   = 3 * F + 3;
    localparam int P_W    = 3 * F + 4;
    localparam int SH     = 3 * F + 1 - WEIGHT_BITS;

    localparam logic [G_W-1:0]        S_VAL = G_W'(1) << F;
    localparam logic [K_W-1:0]        K4S   = K_W'(1) << (F + 2);
    localparam logic [H_W-1:0]        S_SQ  = H_W'(1) << (2 * F);
    localparam logic signed [P_W-1:0] HALF  = P_W'(1) << (SH - 1);
    localparam logic signed [WGT_W-1:0] W_ONE = WGT_W'(1) << WEIGHT_BITS;

    // index 0: horizontal, index 1: vertical
    logic [F-1:0]   f_in [2];
    logic [G_W-1:0] g_in [2];
    logic [K_W-1:0] k_in [2];

    // stage a: f, g = 1 - f, squares and f*(4 - 3f)
    logic           a_valid_reg;
    rows_t          a_rows_reg;
    logic [F-1:0]   a_f_reg  [2];
    logic [G_W-1:0] a_g_reg  [2];
    logic [F2_W-1:0] a_f2_reg [2];
    logic [G2_W-1:0] a_g2_reg [2];
    logic [H_W-1:0] a_h_reg  [2];

    // stage b: unrounded weight numerators
    logic              b_valid_reg;
    rows_t             b_rows_reg;
    logic [H_W-1:0]    b_t      [2];
    logic [CUBE_W-1:0] b_w0m_reg [2];
    logic [CUBE_W-1:0] b_w3m_reg [2];
    logic [W2_W-1:0]   b_w2_reg  [2];

    // stage c: rounded weights
    logic signed [P_W-1:0]   r0 [2];
    logic signed [P_W-1:0]   r2 [2];
    logic signed [P_W-1:0]   r3 [2];
    logic signed [WGT_W-1:0] wn [2][4];
    logic                    c_valid_reg;
    rows_t                   c_rows_reg;
    wgt_vec_t                c_wx_reg;
    wgt_vec_t                c_wy_reg;

    always_comb
    begin
        f_in[0] = F'(frac_x);
        f_in[1] = F'(frac_y);
        for (int i = 0; i < 2; i++)
        begin
            g_in[i] = S_VAL - G_W'(f_in[i]);
            k_in[i] = K4S - (K_W'(f_in[i]) << 1) - K_W'(f_in[i]);
        end
    end

    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            b_t[i] = S_SQ + a_h_reg[i];
        end
    end

    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            r0[i] = HALF - $signed(P_W'(b_w0m_reg[i]));
            r2[i] = HALF + $signed(P_W'(b_w2_reg[i]));
            r3[i] = HALF - $signed(P_W'(b_w3m_reg[i]));
            wn[i][0] = WGT_W'(r0[i] >>> SH);
            wn[i][2] = WGT_W'(r2[i] >>> SH);
            wn[i][3] = WGT_W'(r3[i] >>> SH);
            wn[i][1] = W_ONE - wn[i][0] - wn[i][2] - wn[i][3];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_rows_reg <= in_rows;
            b_rows_reg <= a_rows_reg;
            c_rows_reg <= b_rows_reg;
            for (int i = 0; i < 2; i++)
            begin
                a_f_reg[i]   <= f_in[i];
                a_g_reg[i]   <= g_in[i];
                a_f2_reg[i]  <= F2_W'(f_in[i]) * F2_W'(f_in[i]);
                a_g2_reg[i]  <= G2_W'(g_in[i]) * G2_W'(g_in[i]);
                a_h_reg[i]   <= H_W'(f_in[i]) * H_W'(k_in[i]);
                b_w0m_reg[i] <= CUBE_W'(a_f_reg[i]) * CUBE_W'(a_g2_reg[i]);
                b_w3m_reg[i] <= CUBE_W'(a_f2_reg[i]) * CUBE_W'(a_g_reg[i]);
                b_w2_reg[i]  <= W2_W'(a_f_reg[i]) * W2_W'(b_t[i]);
            end
            for (int c = 0; c < 4; c++)
            begin
                c_wx_reg[c] <= wn[0][c];
                c_wy_reg[c] <= wn[1][c];
            end
        end
    end

    always_comb
    begin
        wgt_out.valid = c_valid_reg;
        wgt_out.rows  = c_rows_reg;
        wgt_out.wx    = c_wx_reg;
        wgt_out.wy    = c_wy_reg;
    end

endmodule

@@ sv/bic_filter.sv @@
// ----------------------------------------------------------------------------
// bic_filter
// four-stage separable filter: row taps, row sums, column taps, final sum
// ----------------------------------------------------------------------------
module bic_filter (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  bic_pkg::wgt_stage_t wgt_in,
    output bic_pkg::sum_stage_t sum_out
);
    import bic_pkg::*;

    logic signed [WGT_W-1:0]  wxs [4];
    logic signed [PIX_W:0]    pxs [4][4];

    // stage d: horizontal products
    logic                      d_valid_reg;
    wgt_vec_t                  d_wy_reg;
    logic signed [PROD_W-1:0]  d_prod_reg [4][4];

    // stage e: row results
    logic                      e_valid_reg;
    wgt_vec_t                  e_wy_reg;
    logic signed [ROW_W-1:0]   e_row_reg [4];

    // stage f: vertical products
    logic signed [WGT_W-1:0]   wys [4];
    logic                      f_valid_reg;
    logic signed [VPROD_W-1:0] f_vprod_reg [4];

    // stage g: total
    logic                      g_valid_reg;
    logic signed [SUM_W-1:0]   g_sum_reg;

    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            wxs[c] = $signed(wgt_in.wx[c]);
            wys[c] = $signed(e_wy_reg[c]);
            for (int r = 0; r < 4; r++)
            begin
                pxs[r][c] = $signed({1'b0, wgt_in.rows[r][PIX_W*c +: PIX_W]});
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
            g_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            d_valid_reg <= wgt_in.valid;
            e_valid_reg <= d_valid_reg;
            f_valid_reg <= e_valid_reg;
            g_valid_reg <= f_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_wy_reg <= wgt_in.wy;
            e_wy_reg <= d_wy_reg;
            for (int r = 0; r < 4; r++)
            begin
                for (int c = 0; c < 4; c++)
                begin
                    d_prod_reg[r][c] <= PROD_W'(wxs[c]) * PROD_W'(pxs[r][c]);
                end
                e_row_reg[r] <= ROW_W'(d_prod_reg[r][0]) + ROW_W'(d_prod_reg[r][1])
                              + ROW_W'(d_prod_reg[r][2]) + ROW_W'(d_prod_reg[r][3]);
                f_vprod_reg[r] <= VPROD_W'(wys[r]) * VPROD_W'(e_row_reg[r]);
            end
            g_sum_reg <= SUM_W'(f_vprod_reg[0]) + SUM_W'(f_vprod_reg[1])
                       + SUM_W'(f_vprod_reg[2]) + SUM_W'(f_vprod_reg[3]);
        end
    end

    always_comb
    begin
        sum_out.valid = g_valid_reg;
        sum_out.sum   = g_sum_reg;
    end

endmodule

@@ sv/bicubic_interpolation_kernel.sv @@
// ----------------------------------------------------------------------------
// bicubic_interpolation_kernel
// catmull-rom bicubic interpolation of one pixel from a 4x4 neighbourhood
// ----------------------------------------------------------------------------
//  channel | dir | payload                                         | transaction
//  nbhd    | in  | row0..row3_pixels (4x8 bit), frac_x, frac_y     | valid & ready
//  result  | out | pixel_out (8 bit), clipped                      | valid & ready
//
//  one neighbourhood per clock unless a result is stuck at the output; each result passes
//  through 3 weight stages, 4 filter stages and 1 saturate/output register
//  rst_n clears all valid bits asynchronously; payload registers are not reset
//  a result held in the output register and not taken freezes every stage;
//  nbhd.ready drops in that cycle, so nothing is lost or repeated
// ----------------------------------------------------------------------------
module bicubic_interpolation_kernel #(
    parameter int FRAC_BITS = 8
) (
    input  logic      clk,
    input  logic      rst_n,
    bic_in_if.sink    nbhd,
    bic_out_if.source result
);
    import bic_pkg::*;

    // clip limit and rounding half unit, both at 2*WEIGHT_BITS fraction bits
    localparam logic signed [SUM_W-1:0] LIM = SUM_W'(255) << (2 * WEIGHT_BITS);
    localparam logic signed [SUM_W-1:0] RND = SUM_W'(1) << (2 * WEIGHT_BITS - 1);

    // global advance: the whole pipe moves unless a finished pixel is stuck
    logic                    en;
    rows_t                   in_rows;
    wgt_stage_t              wgt_st;
    sum_stage_t              sum_st;
    logic signed [SUM_W-1:0] rounded;
    logic [PIX_W-1:0]        pixel_next;
    logic                    clipped_next;

    logic                    out_valid_reg;
    logic [PIX_W-1:0]        pixel_reg;
    logic                    clipped_reg;

    assign en         = !out_valid_reg || result.ready;
    assign nbhd.ready = en;

    // row 0 lands at index 0
    assign in_rows = {nbhd.row3_pixels, nbhd.row2_pixels, nbhd.row1_pixels, nbhd.row0_pixels};

    bic_weight_gen #(
        .FRAC_BITS (FRAC_BITS)
    ) u_weight_gen (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (nbhd.valid),
        .in_rows  (in_rows),
        .frac_x   (nbhd.frac_x),
        .frac_y   (nbhd.frac_y),
        .wgt_out  (wgt_st)
    );

    bic_filter u_filter (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .wgt_in  (wgt_st),
        .sum_out (sum_st)
    );

    // round half up and saturate to 0..255
    always_comb
    begin
        rounded = sum_st.sum + RND;
        priority if (sum_st.sum < 0)
        begin
            pixel_next   = '0;
            clipped_next = 1'b1;
        end
        else if (sum_st.sum > LIM)
        begin
            pixel_next   = '1;
            clipped_next = 1'b1;
        end
        else
        begin
            pixel_next   = rounded[2 * WEIGHT_BITS +: PIX_W];
            clipped_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= sum_st.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pixel_reg   <= pixel_next;
            clipped_reg <= clipped_next;
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.pixel_out = pixel_reg;
    assign result.clipped   = clipped_reg;

endmodule

@@ tb/tb_bicubic_interpolation_kernel.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bicubic_interpolation_kernel
// self-checking bench for the catmull-rom bicubic kernel: directed corner
// neighbourhoods, then random streams under source gaps and sink stalls,
// every output transaction checked against an in-bench fixed-point predictor
// ----------------------------------------------------------------------------
module tb_bicubic_interpolation_kernel;
    import bic_pkg::*;

    localparam int FRAC_BITS    = 8;
    localparam int LATENCY      = 8;
    localparam int DRAIN_CYCLES = 2 * LATENCY;
    localparam int STUCK_LIMIT  = 2000;
    localparam int MAX_REPORTS  = 10;

    // one neighbourhood transaction
    typedef struct packed {
        logic [ROW_BITS-1:0]     row0;
        logic [ROW_BITS-1:0]     row1;
        logic [ROW_BITS-1:0]     row2;
        logic [ROW_BITS-1:0]     row3;
        logic [FRAC_FIELD_W-1:0] frac_x;
        logic [FRAC_FIELD_W-1:0] frac_y;
    } nbhd_item_t;

    // one interpolated pixel transaction
    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             clipped;
    } pixel_result_t;

    // the four cubic taps, in units of 2^-WEIGHT_BITS
    typedef struct packed {
        longint w0;
        longint w1;
        longint w2;
        longint w3;
    } cubic_taps_t;

    logic clk;
    logic rst_n;

    bic_in_if  nbhd ();
    bic_out_if result ();

    bicubic_interpolation_kernel #(
        .FRAC_BITS (FRAC_BITS)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .nbhd   (nbhd),
        .result (result)
    );

    // pixels predicted for accepted neighbourhoods, oldest first
    pixel_result_t expected_pixels[$];

    int error_count   = 0;
    int stuck_cycles  = 0;
    int hold_request  = 0;   // long sink hold-off asked by a test, in cycles
    bit sink_idle_en  = 1'b0;

    // ------------------------------------------------------------------------
    // clock
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------

    // catmull-rom taps for one fraction; the exact weights are scaled by
    // 2*S^3 and rounded half up, tap 1 takes the remainder so they sum to one
    function automatic cubic_taps_t catmull_rom_taps(input logic [FRAC_FIELD_W-1:0] frac);
        cubic_taps_t taps;
        longint      s;
        longint      f;
        longint      f2;
        longint      f3;
        longint      half;
        longint      big0;
        longint      big2;
        longint      big3;
        int          sh;
        sh   = 3 * FRAC_BITS + 1 - WEIGHT_BITS;
        s    = longint'(1) << FRAC_BITS;
        f    = longint'(frac) & (s - 1);
        f2   = f * f;
        f3   = f2 * f;
        half = longint'(1) << (sh - 1);
        big0 = -f3 + 2 * f2 * s - f * s * s;
        big2 = -3 * f3 + 4 * f2 * s + f * s * s;
        big3 = f3 - f2 * s;
        // arithmetic shift of a signed value is a floor
        taps.w0 = (big0 + half) >>> sh;
        taps.w2 = (big2 + half) >>> sh;
        taps.w3 = (big3 + half) >>> sh;
        taps.w1 = (longint'(1) << WEIGHT_BITS) - taps.w0 - taps.w2 - taps.w3;
        return taps;
    endfunction

    // horizontal cubic over one packed row, leftmost pixel in the low byte
    function automatic longint filter_row(input logic [ROW_BITS-1:0] row,
                                          input cubic_taps_t taps);
        return taps.w0 * longint'(row[7:0])   + taps.w1 * longint'(row[15:8]) +
               taps.w2 * longint'(row[23:16]) + taps.w3 * longint'(row[31:24]);
    endfunction

    // full 2-d interpolation, round half up, saturate and flag
    function automatic pixel_result_t interpolate_pixel(input nbhd_item_t it);
        cubic_taps_t   tx;
        cubic_taps_t   ty;
        longint        v;
        longint        upper;
        longint        rounded;
        pixel_result_t res;
        tx    = catmull_rom_taps(it.frac_x);
        ty    = catmull_rom_taps(it.frac_y);
        v     = ty.w0 * filter_row(it.row0, tx) + ty.w1 * filter_row(it.row1, tx) +
                ty.w2 * filter_row(it.row2, tx) + ty.w3 * filter_row(it.row3, tx);
        upper = longint'(255) << (2 * WEIGHT_BITS);
        if (v < 0)
        begin
            res.pixel   = '0;
            res.clipped = 1'b1;
        end
        else if (v > upper)
        begin
            res.pixel   = '1;
            res.clipped = 1'b1;
        end
        else
        begin
            rounded     = (v + (longint'(1) << (2 * WEIGHT_BITS - 1))) >>> (2 * WEIGHT_BITS);
            res.pixel   = rounded[PIX_W-1:0];
            res.clipped = 1'b0;
        end
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    function automatic nbhd_item_t make_nbhd(input logic [ROW_BITS-1:0] r0, r1, r2, r3,
                                             input logic [FRAC_FIELD_W-1:0] fx, fy);
        nbhd_item_t it;
        it.row0   = r0;
        it.row1   = r1;
        it.row2   = r2;
        it.row3   = r3;
        it.frac_x = fx;
        it.frac_y = fy;
        return it;
    endfunction

    // rows with hard edges of zero and full-scale pixels provoke overshoot and so the clipping paths
    function automatic logic [ROW_BITS-1:0] random_row(input bit edgy);
        logic [ROW_BITS-1:0] r;
        int                  b;
        r = $urandom;
        if (edgy)
        begin
            for (b = 0; b < 4; b++)
            begin
                case ($urandom_range(0, 2))
                    0:       r[8*b +: 8] = 8'h00;
                    1:       r[8*b +: 8] = 8'hFF;
                    default: ;
                endcase
            end
        end
        return r;
    endfunction

    // mostly uniform, now and then a corner of the fraction range
    function automatic logic [FRAC_FIELD_W-1:0] random_frac();
        logic [FRAC_FIELD_W-1:0] f;
        f = FRAC_FIELD_W'($urandom_range(0, 255));
        if ($urandom_range(0, 99) < 15)
        begin
            case ($urandom_range(0, 4))
                0:       f = 8'h00;
                1:       f = 8'h01;
                2:       f = 8'h80;
                3:       f = 8'hFE;
                default: f = 8'hFF;
            endcase
        end
        return f;
    endfunction

    function automatic nbhd_item_t random_nbhd();
        bit edgy;
        edgy = ($urandom_range(0, 3) == 0);
        return make_nbhd(random_row(edgy), random_row(edgy), random_row(edgy),
                         random_row(edgy), random_frac(), random_frac());
    endfunction

    // source gap: mostly back to back, some short, a few long
    function automatic int source_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 65)
            return 0;
        else if (roll < 94)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    // sink stall length: mostly short, a few long
    function automatic int stall_length();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    // ------------------------------------------------------------------------
    // sender: called at a rising edge, returns at the edge of acceptance or,
    // if a gap follows, at the end of the gap; valid stays high unless a gap
    // follows, so it is never dropped and raised in one step
    // ------------------------------------------------------------------------
    task automatic send_nbhd(input nbhd_item_t it, input bit idle);
        int gap;
        nbhd.valid       <= 1'b1;
        nbhd.row0_pixels <= it.row0;
        nbhd.row1_pixels <= it.row1;
        nbhd.row2_pixels <= it.row2;
        nbhd.row3_pixels <= it.row3;
        nbhd.frac_x      <= it.frac_x;
        nbhd.frac_y      <= it.frac_y;
        do
            @(posedge clk);
        while (!nbhd.ready);
        gap = idle ? source_gap() : 0;
        if (gap != 0)
        begin
            nbhd.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        nbhd.valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // zero fraction passes p1 / row1 through, in one or both directions
    task automatic test_zero_fraction();
        send_nbhd(make_nbhd($urandom, $urandom, $urandom, $urandom, 8'h00, 8'h00), 1'b0);
        send_nbhd(make_nbhd($urandom, 32'h12345678, $urandom, $urandom, 8'h00, 8'h00), 1'b0);
        send_nbhd(make_nbhd($urandom, $urandom, $urandom, $urandom, 8'h00, 8'h80), 1'b0);
        send_nbhd(make_nbhd($urandom, $urandom, $urandom, $urandom, 8'h80, 8'h00), 1'b0);
        send_nbhd(make_nbhd(32'hFFFFFFFF, 32'h00FF00FF, 32'hFFFFFFFF, 32'h0, 8'h00, 8'h00),
                  1'b0);
    endtask

    // flat fields at the pixel extremes and fractions at the ends of the range
    task automatic test_field_extremes();
        send_nbhd(make_nbhd(32'h0, 32'h0, 32'h0, 32'h0, 8'h00, 8'h00), 1'b0);
        send_nbhd(make_nbhd(32'h0, 32'h0, 32'h0, 32'h0, 8'hFF, 8'hFF), 1'b0);
        send_nbhd(make_nbhd('1, '1, '1, '1, 8'hFF, 8'hFF), 1'b0);
        send_nbhd(make_nbhd('1, '1, '1, '1, 8'h01, 8'hFE), 1'b0);
        send_nbhd(make_nbhd('1, '1, '1, '1, 8'h80, 8'h80), 1'b0);
        send_nbhd(make_nbhd(32'h0, '1, '1, 32'h0, 8'hFF, 8'h01), 1'b0);
        send_nbhd(make_nbhd(32'hFF00FF00, 32'h00FF00FF, 32'hFF00FF00, 32'h00FF00FF,
                            8'h55, 8'hAA), 1'b0);
        send_nbhd(make_nbhd(32'h00FF00FF, 32'hFF00FF00, 32'h00FF00FF, 32'hFF00FF00,
                            8'hAA, 8'h55), 1'b0);
    endtask

    // ringing of the cubic drives the value below 0 or above 255
    task automatic test_saturation();
        // dip in one row: negative after the horizontal pass alone
        send_nbhd(make_nbhd($urandom, 32'hFF0000FF, $urandom, $urandom, 8'h80, 8'h00), 1'b0);
        // bump in one row: above full scale
        send_nbhd(make_nbhd($urandom, 32'h00FFFF00, $urandom, $urandom, 8'h80, 8'h00), 1'b0);
        // dip and bump in both directions
        send_nbhd(make_nbhd('1, 32'hFF0000FF, 32'hFF0000FF, '1, 8'h80, 8'h80), 1'b0);
        send_nbhd(make_nbhd(32'h0, 32'h00FFFF00, 32'h00FFFF00, 32'h0, 8'h80, 8'h80), 1'b0);
        // vertical step only
        send_nbhd(make_nbhd('1, 32'h0, 32'h0, '1, 8'h00, 8'h80), 1'b0);
        send_nbhd(make_nbhd(32'h0, '1, '1, 32'h0, 8'h00, 8'h80), 1'b0);
        // milder overshoot off centre
        send_nbhd(make_nbhd(32'h0, 32'h00FFFF00, 32'h00FFFF00, 32'h0, 8'h40, 8'hC0), 1'b0);
        wait_drained();
    endtask

    // back to back with the sink always ready: full throughput
    task automatic test_streaming(input int count);
        int n;
        sink_idle_en = 1'b0;
        for (n = 0; n < count; n++)
            send_nbhd(random_nbhd(), 1'b0);
        wait_drained();
    endtask

    // sink held off for a long stretch while the source keeps offering,
    // so the pipeline fills and input ready must drop
    task automatic test_backpressure(input int count);
        int n;
        sink_idle_en = 1'b0;
        hold_request = 150;
        for (n = 0; n < count; n++)
            send_nbhd(random_nbhd(), 1'b0);
        wait_drained();
    endtask

    // short bursts with the source pausing until every pixel is back
    task automatic test_drain_pause(input int bursts);
        int b;
        int n;
        sink_idle_en = 1'b1;
        for (b = 0; b < bursts; b++)
        begin
            for (n = 0; n < $urandom_range(5, 20); n++)
                send_nbhd(random_nbhd(), 1'b1);
            wait_drained();
        end
    endtask

    // long random run with idling on both sides
    task automatic test_random_traffic(input int count);
        int n;
        sink_idle_en = 1'b1;
        for (n = 0; n < count; n++)
            send_nbhd(random_nbhd(), 1'b1);
        wait_drained();
    endtask

    // ------------------------------------------------------------------------
    // sink ready: random stalls, or a long hold-off on request
    // ------------------------------------------------------------------------
    initial
    begin
        int hold_cnt;
        hold_cnt = 0;
        result.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_request != 0)
            begin
                hold_cnt     = hold_request;
                hold_request = 0;
            end
            if (hold_cnt == 0 && sink_idle_en && $urandom_range(0, 99) < 20)
                hold_cnt = stall_length();
            if (hold_cnt != 0)
            begin
                result.ready <= 1'b0;
                hold_cnt--;
            end
            else
            begin
                result.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // input monitor: predict the pixel of every accepted neighbourhood
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        nbhd_item_t seen;
        if (rst_n && nbhd.valid && nbhd.ready)
        begin
            seen = make_nbhd(nbhd.row0_pixels, nbhd.row1_pixels, nbhd.row2_pixels,
                             nbhd.row3_pixels, nbhd.frac_x, nbhd.frac_y);
            expected_pixels.push_back(interpolate_pixel(seen));
        end
    end

    // ------------------------------------------------------------------------
    // output checker: compare each pixel transaction with the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        pixel_result_t want;
        if (rst_n && result.valid && result.ready)
        begin
            if (expected_pixels.size() == 0)
            begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("unexpected pixel transaction: pixel %0d clipped %0b",
                             result.pixel_out, result.clipped);
            end
            else
            begin
                want = expected_pixels.pop_front();
                if (result.pixel_out !== want.pixel || result.clipped !== want.clipped)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("pixel mismatch: expected %0d clipped %0b, got %0d clipped %0b",
                                 want.pixel, want.clipped, result.pixel_out, result.clipped);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: cycles with work pending but no transaction on either side
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n || (nbhd.valid && nbhd.ready) || (result.valid && result.ready) ||
            (!nbhd.valid && expected_pixels.size() == 0))
        begin
            stuck_cycles = 0;
        end
        else
        begin
            stuck_cycles++;
            if (stuck_cycles >= STUCK_LIMIT)
            begin
                $display("tb_bicubic_interpolation_kernel failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n            <= 1'b0;
        nbhd.valid       <= 1'b0;
        nbhd.row0_pixels <= '0;
        nbhd.row1_pixels <= '0;
        nbhd.row2_pixels <= '0;
        nbhd.row3_pixels <= '0;
        nbhd.frac_x      <= '0;
        nbhd.frac_y      <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_zero_fraction();
        test_field_extremes();
        test_saturation();
        test_streaming(200);
        test_backpressure(60);
        test_drain_pause(5);
        test_random_traffic(1550);

        // let any stray transaction show up before the verdict
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_pixels.size() != 0)
        begin
            error_count += expected_pixels.size();
            $display("%0d predicted pixels never arrived", expected_pixels.size());
        end

        if (error_count == 0)
            $display("tb_bicubic_interpolation_kernel passed");
        else
            $display("tb_bicubic_interpolation_kernel failed");
        $finish;
    end

endmodule
